// ===== rtl/touch_swipe_detector_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the touch swipe detector
// ---------------------------------------------------------------------------
`ifndef TOUCH_SWIPE_DETECTOR_UNIT_DEFINES_SVH
`define TOUCH_SWIPE_DETECTOR_UNIT_DEFINES_SVH

// Checked at every rising edge, masked while reset is asserted.
`define TSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, including during reset.
`define TSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tsd_pkg.sv =====
// ---------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the touch swipe detector.
// ---------------------------------------------------------------------------
package tsd_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int THRESH_BITS        = 12;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd50;

  // Register index of the swipe threshold (min_travel)
  localparam logic REG_MIN_TRAVEL = 1'b0;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_t;

endpackage

// ===== rtl/tsd_classify.sv =====
// ---------------------------------------------------------------------------
// tsd_classify
// Displacement from the start point and dominant-axis threshold decision.
// ---------------------------------------------------------------------------
module tsd_classify #(
  parameter int COORD_BITS = tsd_pkg::COORD_BITS_DEFAULT
) (
  input  logic [COORD_BITS-1:0]          cur_x,
  input  logic [COORD_BITS-1:0]          cur_y,
  input  logic [COORD_BITS-1:0]          start_x,
  input  logic [COORD_BITS-1:0]          start_y,
  input  logic [tsd_pkg::THRESH_BITS-1:0] threshold,
  output tsd_pkg::dir_t                  dir
);
  import tsd_pkg::*;

  localparam int CMP_W = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;

  logic [COORD_BITS:0]   diff_x;
  logic [COORD_BITS:0]   diff_y;
  logic [COORD_BITS:0]   neg_x;
  logic [COORD_BITS:0]   neg_y;
  logic                  sign_x;
  logic                  sign_y;
  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;
  logic [CMP_W-1:0]      mag_x_ext;
  logic [CMP_W-1:0]      mag_y_ext;
  logic [CMP_W-1:0]      thr_ext;

  assign diff_x = {1'b0, cur_x} - {1'b0, start_x};
  assign diff_y = {1'b0, cur_y} - {1'b0, start_y};
  assign neg_x  = '0 - diff_x;
  assign neg_y  = '0 - diff_y;
  assign sign_x = diff_x[COORD_BITS];
  assign sign_y = diff_y[COORD_BITS];
  // magnitude of a difference of two unsigned values fits in COORD_BITS
  assign mag_x  = sign_x ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
  assign mag_y  = sign_y ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

  assign mag_x_ext = CMP_W'(mag_x);
  assign mag_y_ext = CMP_W'(mag_y);
  assign thr_ext   = CMP_W'(threshold);

  always_comb begin
    dir = DIR_NONE;
    if (mag_x > mag_y) begin
      if (mag_x_ext > thr_ext) begin
        dir = sign_x ? DIR_LEFT : DIR_RIGHT;
      end
    end else begin
      // ties go to the Y axis
      if (mag_y_ext > thr_ext) begin
        dir = sign_y ? DIR_UP : DIR_DOWN;
      end
    end
  end

endmodule

// ===== rtl/touch_swipe_detector_unit.sv =====
// ---------------------------------------------------------------------------
// touch_swipe_detector_unit
// Swipe gesture detector over a stream of touch samples.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample per transaction:
//   touch_down, pos_x, pos_y. Output channel (out_valid/out_ready) returns
//   one direction code per sample: 0 none, 1 right, 2 left, 3 down, 4 up.
//   The APB port holds the swipe threshold at byte address 0; pready is tied
//   high.
//   The result passes through the input register, then the result register,
//   before the result transaction. Throughput: one sample per cycle when the
//   receiver does not stall, set by the single subtract/compare/flag-update
//   pass between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are occupied and out_ready
//   is low. Tracking state advances only when a sample moves into the
//   result register, so stalls never skip or repeat a sample.
//   Reset (rst, synchronous) empties both registers, sets threshold to 50,
//   clears the start point and tracking, and marks the lift as already seen.
//   Write threshold only while the block is idle.
// ---------------------------------------------------------------------------
`include "touch_swipe_detector_unit_defines.svh"

module touch_swipe_detector_unit #(
  parameter int COORD_BITS = tsd_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  touch_down,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            direction,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tsd_pkg::*;

  // configuration
  logic [THRESH_BITS-1:0] min_travel;
  logic                   cfg_write;

  // input register
  logic                  s1_valid;
  logic                  s1_touch;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;

  // result register
  dir_t                  out_dir;

  // gesture state
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic                  tracking;
  logic                  released;
  logic [COORD_BITS-1:0] start_x_next;
  logic [COORD_BITS-1:0] start_y_next;
  logic                  tracking_next;
  logic                  released_next;

  logic                  advance;
  dir_t                  cls_dir;
  dir_t                  dir_next;

  // ---------------------------------------------------------------- APB ---
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_travel <= THRESH_RESET;
    end else if (cfg_write && (paddr[2] == REG_MIN_TRAVEL)) begin
      min_travel <= pwdata[THRESH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_TRAVEL) begin
      prdata = 32'(min_travel);
    end
  end

  // ---------------------------------------------------------- handshake ---
  // The result register frees when empty or being taken; the input register
  // moves into it then.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_touch <= touch_down;
      s1_x     <= pos_x;
      s1_y     <= pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_dir <= dir_next;
    end
  end

  assign direction = out_dir;

  // ------------------------------------------------------ gesture logic ---
  tsd_classify #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .cur_x    (s1_x),
    .cur_y    (s1_y),
    .start_x  (start_x),
    .start_y  (start_y),
    .threshold(min_travel),
    .dir      (cls_dir)
  );

  always_comb begin
    dir_next      = DIR_NONE;
    start_x_next  = start_x;
    start_y_next  = start_y;
    tracking_next = tracking;
    released_next = released;
    if (!released && s1_touch) begin
      // still held after a swipe: wait for lift
    end else begin
      released_next = 1'b1;
      if (tracking && !s1_touch) begin
        tracking_next = 1'b0;
      end else if (!tracking && s1_touch) begin
        // new touch: latch start point, zero coordinates included
        tracking_next = 1'b1;
        start_x_next  = s1_x;
        start_y_next  = s1_y;
      end else if (tracking && (s1_x != '0) && (s1_y != '0)) begin
        dir_next = cls_dir;
        if (cls_dir != DIR_NONE) begin
          tracking_next = 1'b0;
          released_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x  <= '0;
      start_y  <= '0;
      tracking <= 1'b0;
      released <= 1'b1;
    end else if (advance && s1_valid) begin
      start_x  <= start_x_next;
      start_y  <= start_y_next;
      tracking <= tracking_next;
      released <= released_next;
    end
  end

  // --------------------------------------------------------- assertions ---
  `TSD_ASSERT(a_swipe_rearms,
    (advance && s1_valid && dir_next != DIR_NONE) |=> (!released && !tracking),
    "swipe did not end tracking")
  `TSD_ASSERT(a_hold_quiet,
    (advance && s1_valid && !released && s1_touch) |=>
      (out_dir == DIR_NONE && $stable(tracking) && $stable(start_x) && $stable(start_y)),
    "held touch after swipe changed state")
  `TSD_ASSERT(a_ready_follows, out_ready |-> in_ready, "input stalled while output drains")
  `TSD_ASSERT_ALWAYS(a_reset_state,
    rst |=> (released && !tracking && !out_valid && !s1_valid),
    "reset state wrong")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Testbench for touch_swipe_detector_unit
// Drives touch samples over the valid/ready input channel, predicts one
// direction code per sample and checks it in order against the result
// channel. A short directed table comes first, then random gestures under
// several swipe thresholds set over APB, with random idle and stall bursts.
// ============================================================================
module testbench;
  import tsd_pkg::*;

  localparam int CRD_W = 12;
  // Byte address of the swipe threshold on the APB port
  localparam logic [2:0] THRESH_ADDR = 3'(4 * int'(REG_MIN_TRAVEL));
  // Cycles to let pass after the last result before touching config or ending
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEMS_TOTAL = 1600;
  localparam int N_DIRECTED = 25;

  // One row of the directed table; has_dir marks a typed-in expectation,
  // otherwise the row is checked against the predictor.
  typedef struct packed {
    logic             touch;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic             has_dir;
    dir_t             dir;
  } sample_row_t;

  localparam sample_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 12'd0,    12'd0,    1'b1, DIR_NONE},  // idle after reset
    '{1'b1, 12'd100,  12'd100,  1'b1, DIR_NONE},  // new touch
    '{1'b1, 12'd151,  12'd100,  1'b1, DIR_RIGHT}, // just over threshold
    '{1'b1, 12'd300,  12'd300,  1'b1, DIR_NONE},  // waiting for lift
    '{1'b0, 12'd0,    12'd0,    1'b1, DIR_NONE},  // lift
    '{1'b1, 12'd4095, 12'd4095, 1'b1, DIR_NONE},  // start at max corner
    '{1'b1, 12'd4045, 12'd4095, 1'b0, DIR_NONE},  // exactly at threshold
    '{1'b1, 12'd4044, 12'd4095, 1'b1, DIR_LEFT},
    '{1'b0, 12'd4095, 12'd4095, 1'b1, DIR_NONE},  // lift, coords ignored
    '{1'b1, 12'd1,    12'd1,    1'b1, DIR_NONE},  // start at min corner
    '{1'b1, 12'd1,    12'd51,   1'b0, DIR_NONE},
    '{1'b1, 12'd1,    12'd52,   1'b0, DIR_NONE},
    '{1'b0, 12'd0,    12'd0,    1'b1, DIR_NONE},
    '{1'b1, 12'd2000, 12'd2000, 1'b1, DIR_NONE},
    '{1'b1, 12'd2060, 12'd2060, 1'b0, DIR_NONE},  // tie goes to Y axis
    '{1'b0, 12'd7,    12'd9,    1'b1, DIR_NONE},
    '{1'b1, 12'd2000, 12'd2000, 1'b1, DIR_NONE},
    '{1'b1, 12'd0,    12'd1000, 1'b0, DIR_NONE},  // zero X: no swipe
    '{1'b1, 12'd2000, 12'd0,    1'b0, DIR_NONE},  // zero Y: no swipe
    '{1'b1, 12'd1000, 12'd1000, 1'b0, DIR_NONE},  // tie, upward
    '{1'b0, 12'd0,    12'd0,    1'b1, DIR_NONE},
    '{1'b1, 12'd0,    12'd0,    1'b1, DIR_NONE},  // zero start point stored
    '{1'b0, 12'd5,    12'd5,    1'b1, DIR_NONE},  // lift while tracking
    '{1'b1, 12'd0,    12'd0,    1'b1, DIR_NONE},
    '{1'b1, 12'd4095, 12'd1,    1'b0, DIR_NONE}   // full-scale move
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             touch_down;
  logic [CRD_W-1:0] pos_x;
  logic [CRD_W-1:0] pos_y;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       direction;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // predictor state
  logic [CRD_W-1:0] anchor_x;
  logic [CRD_W-1:0] anchor_y;
  bit               tracking;
  bit               lift_seen;
  logic [11:0]      swipe_thr;

  dir_t pending_dirs[$];
  int   errors = 0;
  int   accepted = 0;
  bit   gaps_on = 1'b0;   // sender idle bursts enabled
  bit   stall_on = 1'b0;  // receiver stall bursts enabled
  int   stall_left = 0;

  touch_swipe_detector_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .touch_down(touch_down),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .direction (direction),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Direction the detector should answer for one sample; advances the
  // tracked gesture the same way the block does.
  function automatic dir_t swipe_predict(bit touch, logic [CRD_W-1:0] cx,
                                         logic [CRD_W-1:0] cy);
    int   dx;
    int   dy;
    int   thr;
    int   mag_x;
    int   mag_y;
    dir_t d;
    d = DIR_NONE;
    // swipe already reported, finger still down
    if (!lift_seen && touch) return DIR_NONE;
    lift_seen = 1'b1;
    if (tracking && !touch) begin
      tracking = 1'b0;
      return DIR_NONE;
    end
    if (!tracking && touch) begin
      tracking = 1'b1;
      anchor_x = cx;
      anchor_y = cy;
      return DIR_NONE;
    end
    if (!tracking) return DIR_NONE;
    if (cx == '0 || cy == '0) return DIR_NONE;
    dx = int'(cx) - int'(anchor_x);
    dy = int'(cy) - int'(anchor_y);
    thr = int'(swipe_thr);
    mag_x = (dx < 0) ? -dx : dx;
    mag_y = (dy < 0) ? -dy : dy;
    if (mag_x > mag_y) begin
      if (dx > thr) d = DIR_RIGHT;
      else if (dx < -thr) d = DIR_LEFT;
    end else begin
      if (dy > thr) d = DIR_DOWN;
      else if (dy < -thr) d = DIR_UP;
    end
    if (d != DIR_NONE) begin
      tracking = 1'b0;
      lift_seen = 1'b0;
    end
    return d;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  // Called right after a rising edge; returns right after the edge at which
  // the transaction was accepted. in_valid stays high for the next sample.
  task automatic send_sample(bit touch, logic [CRD_W-1:0] x, logic [CRD_W-1:0] y,
                             bit has_dir = 1'b0, dir_t want = DIR_NONE);
    int   gap;
    dir_t d;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    touch_down <= touch;
    pos_x      <= x;
    pos_y      <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    d = swipe_predict(touch, x, y);
    pending_dirs.push_back(has_dir ? want : d);
    accepted++;
  endtask

  // Stop sending and let every outstanding result come back and any
  // receiver stall burst run out.
  task automatic drain();
    in_valid <= 1'b0;
    stall_on = 1'b0;
    while (pending_dirs.size() != 0 || stall_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle (pready is tied high).
  task automatic write_threshold(logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESH_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    swipe_thr = value;
  endtask

  // Coordinate displaced from base: mostly near the threshold, sometimes
  // small or arbitrary moves, now and then an invalid zero.
  function automatic logic [CRD_W-1:0] displaced(logic [CRD_W-1:0] base);
    int off;
    int v;
    case ($urandom_range(0, 11))
      0: return '0;
      1, 2: off = $urandom_range(0, 4095);
      3, 4, 5: off = $urandom_range(0, int'(swipe_thr));
      default: off = int'(swipe_thr) + $urandom_range(0, 4) - 2;
    endcase
    if ($urandom_range(0, 1) == 1) off = -off;
    v = int'(base) + off;
    if (v < 1) v = 1;
    if (v > 4095) v = 4095;
    return CRD_W'(v);
  endfunction

  function automatic logic [CRD_W-1:0] any_coord();
    return ($urandom_range(0, 15) == 0) ? '0 : CRD_W'($urandom_range(1, 4095));
  endfunction

  // Mostly a lift, a touch-down and a run of noisy held samples; or one sample.
  task automatic run_gesture();
    logic [CRD_W-1:0] sx;
    logic [CRD_W-1:0] sy;
    int               held;
    if ($urandom_range(0, 5) == 0) begin
      send_sample(1'($urandom_range(0, 1)), CRD_W'($urandom), CRD_W'($urandom));
      return;
    end
    if ($urandom_range(0, 7) != 0)
      send_sample(1'b0, CRD_W'($urandom), CRD_W'($urandom));
    sx = any_coord();
    sy = any_coord();
    send_sample(1'b1, sx, sy);
    held = $urandom_range(1, 7);
    repeat (held) begin
      if ($urandom_range(0, 3) == 0)
        send_sample(1'b1, displaced(sx), sy);
      else if ($urandom_range(0, 2) == 0)
        send_sample(1'b1, sx, displaced(sy));
      else
        send_sample(1'b1, displaced(sx), displaced(sy));
    end
  endtask

  // Receiver: random stall bursts while enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every result transaction against the oldest expectation.
  always @(posedge clk) begin
    dir_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_dirs.size() == 0) begin
        report_mismatch("unexpected result, direction", -1, int'(direction));
      end else begin
        want = pending_dirs.pop_front();
        if (direction !== want)
          report_mismatch("direction", int'(want), int'(direction));
      end
    end
  end

  // Stimulus
  initial begin
    logic [11:0] thr_list [6];
    int          per_phase;
    int          goal;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    touch_down <= 1'b0;
    pos_x      <= '0;
    pos_y      <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    anchor_x  = '0;
    anchor_y  = '0;
    tracking  = 1'b0;
    lift_seen = 1'b1;
    swipe_thr = THRESH_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table at the reset threshold
    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(DIRECTED[i].touch, DIRECTED[i].x, DIRECTED[i].y,
                  DIRECTED[i].has_dir, DIRECTED[i].dir);
    drain();

    // random phases; extremes of the threshold included, last one gap-free
    thr_list = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(2, 4094)),
                 12'd200, 12'd50};
    per_phase = ITEMS_TOTAL / 6;
    for (int p = 0; p < 6; p++) begin
      write_threshold(thr_list[p]);
      goal = accepted + per_phase;
      while (accepted < goal) begin
        // alternate stretches with and without idling
        gaps_on  = (p != 5) && ($urandom_range(0, 2) != 0);
        stall_on = (p != 5) && ($urandom_range(0, 2) != 0);
        run_gesture();
      end
      drain();
    end

    gaps_on  = 1'b0;
    stall_on = 1'b0;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(8_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
